// ===== rtl/graph_dismantlability_check_macros.svh =====
// Assertion macros shared by the dismantlability checker RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef GRAPH_DISMANTLABILITY_CHECK_MACROS_SVH
`define GRAPH_DISMANTLABILITY_CHECK_MACROS_SVH
`ifndef ASSERT_OFF
`define GDC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GDC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GDC_ASSERT(label, clk, rst_n, prop, msg)
`define GDC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/gdc_pkg.sv =====
// Types and constants for the graph dismantlability checker.
// No dependencies; used by gdc_core and graph_dismantlability_check.
package gdc_pkg;

  localparam int unsigned EDGE_FIELD_BITS = 28;

  typedef struct packed {
    logic [3:0]  vertex_count;
    logic [27:0] edge_bits;
  } in_t;

  typedef struct packed {
    logic       dismantlable;
    logic [2:0] deletions_done;
  } out_t;

  // Status from the search engine to the top level.
  typedef struct packed {
    logic       idle;
    logic       done;
    logic       verdict;
    logic [2:0] dels;
  } gdc_stat_t;

endpackage

// ===== rtl/gdc_core.sv =====
// Greedy dismantling engine: a sequencer around one shared cone test.
// Depends on gdc_pkg.
module gdc_core #(
  parameter int unsigned MaxVertices = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              level_i,
  input  gdc_pkg::in_t      item_i,
  input  logic              free_i,
  output gdc_pkg::gdc_stat_t stat_o
);
  import gdc_pkg::*;

  localparam int unsigned IW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CW = $clog2(MaxVertices + 1);
  localparam logic [CW-1:0] LastCnt = CW'(MaxVertices);
  localparam logic [CW-1:0] CntOne = CW'(1);
  localparam logic [MaxVertices-1:0] One = MaxVertices'(1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_OROUND = 3'd1;
  localparam logic [2:0] ST_OSCAN  = 3'd2;
  localparam logic [2:0] ST_IROUND = 3'd3;
  localparam logic [2:0] ST_ISCAN  = 3'd4;
  localparam logic [2:0] ST_CONE   = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [MaxVertices-1:0] adj_q [MaxVertices];
  logic [MaxVertices-1:0] adj_d [MaxVertices];
  logic [MaxVertices-1:0] s_q, s_d, t_q, t_d, c_q, c_d;
  logic [CW-1:0] u_q, u_d, v_q, v_d, w_q, w_d;
  logic lvl_q, lvl_d, verdict_q, verdict_d;
  logic [2:0] del_q, del_d;

  logic [CW-1:0] n_sat;
  logic [MaxVertices-1:0] all_mask;
  logic [MaxVertices-1:0] u_bit, v_bit, w_bit, olink, ilink;
  logic s_single, t_single, cone_hit;

  // Saturated vertex count and the full vertex set of a new item.
  always_comb begin
    n_sat = (item_i.vertex_count > 4'(MaxVertices)) ? LastCnt : CW'(item_i.vertex_count);
    for (int i = 0; i < MaxVertices; i++) begin
      all_mask[i] = (i < int'(n_sat));
    end
  end

  // Adjacency rows unpacked from the upper-triangle edge bits.
  always_comb begin
    int k;
    k = 0;
    for (int r = 0; r < MaxVertices; r++) begin
      adj_d[r] = '0;
    end
    for (int j = 1; j < MaxVertices; j++) begin
      for (int i = 0; i < j; i++) begin
        k = j * (j - 1) / 2 + i;
        if (k < int'(EDGE_FIELD_BITS) && j < int'(n_sat) && item_i.edge_bits[k[4:0]]) begin
          adj_d[i][j] = 1'b1;
          adj_d[j][i] = 1'b1;
        end
      end
    end
  end

  // Links of the scanned vertices and the shared cone test on one member.
  assign u_bit    = One << u_q[IW-1:0];
  assign v_bit    = One << v_q[IW-1:0];
  assign w_bit    = One << w_q[IW-1:0];
  assign olink    = adj_q[u_q[IW-1:0]] & s_q & ~u_bit;
  assign ilink    = adj_q[v_q[IW-1:0]] & t_q & ~v_bit;
  assign s_single = (s_q != '0) && ((s_q & (s_q - One)) == '0);
  assign t_single = (t_q != '0) && ((t_q & (t_q - One)) == '0);
  assign cone_hit = ((c_q & w_bit) != '0) && ((adj_q[w_q[IW-1:0]] & c_q) == (c_q & ~w_bit));

  // Sequencer: outer rounds, inner rounds at level 1, one cone member a cycle.
  always_comb begin
    state_d = state_q;
    s_d = s_q; t_d = t_q; c_d = c_q;
    u_d = u_q; v_d = v_q; w_d = w_q;
    lvl_d = lvl_q; verdict_d = verdict_q; del_d = del_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          s_d = all_mask;
          lvl_d = level_i;
          del_d = '0;
          state_d = ST_OROUND;
        end
      end
      ST_OROUND: begin
        u_d = '0;
        if (s_single) begin
          verdict_d = 1'b1;
          state_d = ST_DONE;
        end else if (s_q == '0) begin
          verdict_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_OSCAN;
        end
      end
      ST_OSCAN: begin
        if (u_q == LastCnt) begin
          verdict_d = 1'b0;
          state_d = ST_DONE;
        end else if (((s_q & u_bit) == '0) || (olink == '0)) begin
          u_d = u_q + CntOne;
        end else if (!lvl_q) begin
          c_d = olink;
          w_d = '0;
          state_d = ST_CONE;
        end else begin
          t_d = olink;
          state_d = ST_IROUND;
        end
      end
      ST_IROUND: begin
        v_d = '0;
        if (t_single) begin
          s_d = s_q & ~u_bit;
          if (del_q != 3'd7) del_d = del_q + 3'd1;
          state_d = ST_OROUND;
        end else if (t_q == '0) begin
          u_d = u_q + CntOne;
          state_d = ST_OSCAN;
        end else begin
          state_d = ST_ISCAN;
        end
      end
      ST_ISCAN: begin
        if (v_q == LastCnt) begin
          u_d = u_q + CntOne;
          state_d = ST_OSCAN;
        end else if (((t_q & v_bit) == '0) || (ilink == '0)) begin
          v_d = v_q + CntOne;
        end else begin
          c_d = ilink;
          w_d = '0;
          state_d = ST_CONE;
        end
      end
      ST_CONE: begin
        if (w_q == LastCnt) begin
          if (!lvl_q) begin
            u_d = u_q + CntOne;
            state_d = ST_OSCAN;
          end else begin
            v_d = v_q + CntOne;
            state_d = ST_ISCAN;
          end
        end else if (cone_hit) begin
          if (!lvl_q) begin
            s_d = s_q & ~u_bit;
            if (del_q != 3'd7) del_d = del_q + 3'd1;
            state_d = ST_OROUND;
          end else begin
            t_d = t_q & ~v_bit;
            state_d = ST_IROUND;
          end
        end else begin
          w_d = w_q + CntOne;
        end
      end
      ST_DONE: begin
        if (free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working sets, counters and the graph itself.
  always_ff @(posedge clk_i) begin
    s_q <= s_d; t_q <= t_d; c_q <= c_d;
    u_q <= u_d; v_q <= v_d; w_q <= w_d;
    lvl_q <= lvl_d; verdict_q <= verdict_d; del_q <= del_d;
    if (state_q == ST_IDLE && start_i) begin
      adj_q <= adj_d;
    end
  end

  assign stat_o.idle    = (state_q == ST_IDLE);
  assign stat_o.done    = (state_q == ST_DONE);
  assign stat_o.verdict = verdict_q;
  assign stat_o.dels    = del_q;

endmodule

// ===== rtl/graph_dismantlability_check.sv =====
// Top level of the graph dismantlability checker: handshakes and result register.
// Depends on gdc_pkg, gdc_core and graph_dismantlability_check_macros.svh.
//
//  channel  signals                        direction
//  in       in_valid_i/in_ready_o/in_data_i   graph in
//  out      out_valid_o/out_ready_i/out_data_o verdict out
//  cfg      cfg_we_i/cfg_wdata_i            level register write
//
// An item is worked by the single cone tester, which checks one link member per cycle
// under the scan sequencer, at level 0 or level 1. One item is in work at a time.
// The result register frees the engine; the engine waits in its done state only
// while a previous result is still unread. Reset clears the level to 0.
`include "graph_dismantlability_check_macros.svh"
module graph_dismantlability_check #(
  parameter int unsigned MaxVertices = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gdc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gdc_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);
  import gdc_pkg::*;

  logic      level_q;
  logic      out_valid_q;
  out_t      out_q;
  gdc_stat_t stat;
  logic      in_xfer, res_free, res_load;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign res_free = !out_valid_q || out_ready_i;
  assign res_load = stat.done && res_free;
  assign in_ready_o = stat.idle;

  gdc_core #(.MaxVertices(MaxVertices)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_xfer),
    .level_i(level_q),
    .item_i (in_data_i),
    .free_i (res_free),
    .stat_o (stat)
  );

  // Level register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
    end else if (cfg_we_i) begin
      level_q <= cfg_wdata_i;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q.dismantlable   <= stat.verdict;
      out_q.deletions_done <= stat.dels;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GDC_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_xfer |=> !in_ready_o, "accepted while busy")
  `GDC_ASSERT(a_load_from_done, clk_i, rst_ni, res_load |=> out_valid_q, "result lost")
  `GDC_ASSERT_NEVER(a_idle_and_done, clk_i, rst_ni, stat.idle && stat.done, "engine state clash")
  `GDC_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)), "result dropped while stalled")

endmodule
